FILE: hdl/pcal_pkg.sv
`default_nettype none
package pcal_pkg;

  localparam int NUM_POINTS = 8;
  localparam int PT_AW = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;

  localparam int DIV_NUM_W = 32;
  localparam int DIV_DEN_W = 16;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  localparam logic [15:0] MIN_SETPOINT = 16'd10;
  localparam logic [15:0] AVG_SCALE = 16'd10000;
  localparam logic signed [33:0] OFFSET_MAX = 34'sd65535;

  localparam logic [1:0] MODE_AVERAGE = 2'd1;
  localparam logic [1:0] MODE_TABLE = 2'd2;

  localparam logic [1:0] CFG_APPLY_MODE = 2'd0;
  localparam logic [1:0] CFG_CAL_TEST = 2'd1;
  localparam logic [1:0] CFG_CAL_SAVED = 2'd2;
  localparam logic [1:0] CFG_AVG_PERCENT = 2'd3;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_COMPUTE = 1'b1;

  typedef enum logic [2:0] {
    STAT_DISABLED = 3'd0,
    STAT_BELOW_MIN = 3'd1,
    STAT_HIT = 3'd2,
    STAT_MISS = 3'd3,
    STAT_AVERAGE = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CMP,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FINISH,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: hdl/pcal_div.sv
`default_nettype none
module pcal_div
  import pcal_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [DIV_NUM_W-1:0] dividend,
  input  wire logic [DIV_DEN_W-1:0] divisor,
  output logic                      done,
  output logic [DIV_NUM_W-1:0]      quot,
  output logic [DIV_DEN_W-1:0]      remainder
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_DEN_W:0]   shifted;
  logic                 take;

  // restoring division, one quotient bit per cycle
  always_comb begin
    shifted = {remainder, quot[DIV_NUM_W-1]};
    take = (shifted >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      remainder <= '0;
      den <= divisor;
    end else if (busy) begin
      quot <= {quot[DIV_NUM_W-2:0], take};
      remainder <= take ? DIV_DEN_W'(shifted - {1'b0, den}) : shifted[DIV_DEN_W-1:0];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/power_calibration_offset_top.sv
`default_nettype none
// channel   | signals                         | moves
// ----------+---------------------------------+-------------------------------------
// s_axis    | tvalid tready tdata[55:0] tuser | load point or compute setpoint item
// m_axis    | tvalid tready tdata[23:0] tuser | offset and status result
// cfg       | valid ready index[1:0] data     | register write
//
// a load item is written to the table as it is taken. a compute item goes straight
// to the done state when disabled or below minimum; in lookup it steps through
// fetch and compare per table segment; average mode, or an interpolated hit, adds
// the multiply and the 32-step serial divider.
// rst is synchronous; table contents are undefined until loaded.
// a finished result waits in the output register while the next item is taken.
module power_calibration_offset_top
  import pcal_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,  // point_index, point_power, point_meter, setpoint
  input  wire logic        s_axis_tuser,  // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // offset
  output logic [2:0]       m_axis_tuser,  // status
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [14:0] cfg_data
);

  logic [2:0]  in_point_index;
  logic [15:0] in_point_power;
  logic [15:0] in_point_meter;
  logic [15:0] in_setpoint;

  assign in_point_index = s_axis_tdata[2:0];
  assign in_point_power = s_axis_tdata[18:3];
  assign in_point_meter = s_axis_tdata[34:19];
  assign in_setpoint    = s_axis_tdata[50:35];

  // configuration registers
  logic [1:0]         apply_mode;
  logic               cal_test_active;
  logic               cal_saved;
  logic signed [14:0] average_percent;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      apply_mode <= '0;
      cal_test_active <= 1'b0;
      cal_saved <= 1'b0;
      average_percent <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_APPLY_MODE:  apply_mode <= cfg_data[1:0];
        CFG_CAL_TEST:    cal_test_active <= cfg_data[0];
        CFG_CAL_SAVED:   cal_saved <= cfg_data[0];
        CFG_AVG_PERCENT: average_percent <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // calibration table
  logic [15:0] power_mem [NUM_POINTS];
  logic [15:0] meter_mem [NUM_POINTS];
  logic [15:0] rd_power;
  logic [15:0] rd_meter;
  logic [PT_AW-1:0] seg;

  logic in_xfer;
  logic in_load;
  logic in_compute;

  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign in_load = in_xfer && (s_axis_tuser == KIND_LOAD);
  assign in_compute = in_xfer && (s_axis_tuser == KIND_COMPUTE);

  always_ff @(posedge clk) begin
    if (in_load && (32'(in_point_index) < NUM_POINTS)) begin
      power_mem[PT_AW'(in_point_index)] <= in_point_power;
      meter_mem[PT_AW'(in_point_index)] <= in_point_meter;
    end
    rd_power <= power_mem[seg];
    rd_meter <= meter_mem[seg];
  end

  // sequencer
  state_t state;
  state_t state_next;

  logic disabled;
  logic below_min;
  logic seg_hit;
  logic seg_last;
  logic [15:0] dy;
  logic div_start;
  logic div_done;
  logic out_load;

  logic [15:0] set_reg;
  logic [15:0] lo_x;
  logic [15:0] lo_y;

  assign disabled = !(apply_mode inside {MODE_AVERAGE, MODE_TABLE}) || cal_test_active ||
                    !cal_saved;
  assign below_min = (in_setpoint < MIN_SETPOINT);
  assign seg_hit = (set_reg >= lo_y) && (set_reg <= rd_meter);
  assign seg_last = (seg == PT_AW'(NUM_POINTS - 1));
  assign dy = rd_meter - lo_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_compute) begin
          if (disabled || below_min) begin
            state_next = ST_DONE;
          end else if (apply_mode == MODE_TABLE) begin
            state_next = ST_FETCH;
          end else begin
            state_next = ST_MUL;
          end
        end
      end
      ST_FETCH: state_next = ST_CMP;
      ST_CMP: begin
        if (seg_hit) begin
          state_next = (dy == '0) ? ST_DONE : ST_MUL;
        end else if (seg_last) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_FETCH;
        end
      end
      ST_MUL:       state_next = ST_DIV_START;
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: state_next = ST_DONE;
      ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    div_start = (state == ST_DIV_START);
    out_load = (state == ST_DONE) && (!m_axis_tvalid || m_axis_tready);
  end

  // shared multiply and divide datapath
  logic signed [16:0] op_a;
  logic signed [16:0] op_b;
  logic [15:0]        den;
  logic signed [33:0] prod;
  logic               is_avg;
  logic               neg;
  logic [33:0]        prod_mag;

  logic [DIV_NUM_W-1:0] quot;
  logic [DIV_DEN_W-1:0] rem;

  logic               round_up;
  logic [32:0]        q_round;
  logic signed [33:0] q_signed;
  logic signed [33:0] interp_off;
  logic signed [33:0] avg_off;

  logic signed [16:0] res_offset;
  status_t            res_status;

  assign prod_mag = prod[33] ? 34'(-prod) : 34'(prod);

  pcal_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (prod_mag[DIV_NUM_W-1:0]),
    .divisor   (den),
    .done      (div_done),
    .quot      (quot),
    .remainder (rem)
  );

  // round half away from zero: bump when twice the remainder reaches the divisor
  always_comb begin
    round_up = ({rem, 1'b0} >= {1'b0, den});
    q_round = {1'b0, quot} + 33'(round_up);
    q_signed = neg ? -$signed({1'b0, q_round}) : $signed({1'b0, q_round});
    interp_off = $signed({18'd0, lo_x}) + q_signed - $signed({18'd0, set_reg});
    if (q_signed > OFFSET_MAX) begin
      avg_off = OFFSET_MAX;
    end else if (q_signed < -OFFSET_MAX) begin
      avg_off = -OFFSET_MAX;
    end else begin
      avg_off = q_signed;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        set_reg <= in_setpoint;
        lo_x <= '0;
        lo_y <= '0;
        seg <= '0;
        is_avg <= (apply_mode == MODE_AVERAGE);
        op_a <= 17'(average_percent);
        op_b <= $signed({1'b0, in_setpoint});
        den <= AVG_SCALE;
        res_offset <= '0;
        if (disabled) begin
          res_status <= STAT_DISABLED;
        end else begin
          res_status <= STAT_BELOW_MIN;
        end
      end
      ST_CMP: begin
        op_a <= $signed({1'b0, rd_power}) - $signed({1'b0, lo_x});
        op_b <= $signed({1'b0, set_reg - lo_y});
        den <= dy;
        if (seg_hit) begin
          res_status <= STAT_HIT;
          res_offset <= $signed({1'b0, lo_x}) - $signed({1'b0, set_reg});
        end else begin
          res_status <= STAT_MISS;
          res_offset <= '0;
          lo_x <= rd_power;
          lo_y <= rd_meter;
          seg <= seg + 1'b1;
        end
      end
      ST_MUL: prod <= op_a * op_b;
      ST_DIV_START: neg <= prod[33];
      ST_FINISH: begin
        if (is_avg) begin
          res_offset <= avg_off[16:0];
          res_status <= STAT_AVERAGE;
        end else begin
          res_offset <= interp_off[16:0];
          res_status <= STAT_HIT;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {7'd0, res_offset};
      m_axis_tuser <= res_status;
    end
  end

endmodule
`default_nettype wire
